/* hdl/wip_pkg.sv */
`default_nettype none

package wip_pkg;

  // fixed field widths of the beats
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned DRAW_W   = 32;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_PICK   = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_PICK_OK = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_ZERO    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ADDR = 3'b010,
    S_CMP  = 3'b100
  } state_e;

endpackage

`default_nettype wire

/* hdl/wip_scale.sv */
`default_nettype none

// Registered draw * total; the upper word is the scaled target.
module wip_scale #(
  parameter int unsigned TOT_W = 26
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [wip_pkg::DRAW_W-1:0]  draw_i,
  input  wire logic [TOT_W-1:0]            total_i,
  output logic      [TOT_W-1:0]            target_o
);
  import wip_pkg::*;

  localparam int unsigned PROD_W = DRAW_W + TOT_W;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(draw_i) * PROD_W'(total_i);
    end
  end

  assign target_o = prod_q[PROD_W-1:DRAW_W];

endmodule

`default_nettype wire

/* hdl/weighted_index_picker.sv */
`default_nettype none

// Channel   Direction  Handshake                  Payload
// request   in         start & !busy              req_type_i, weight_i, random_draw_i
// result    out        result_valid_o (one cycle) picked_index_o, status_o, entry_count_o
//
// Clear, append and rejected requests: the result beat appears in the cycle after
// the request is taken. A pick loads the product register on the taking edge,
// then runs binary-search steps of a table read (S_ADDR) and a compare (S_CMP),
// as the table has a single read port; a last S_ADDR visit closes the search
// and registers the result beat.
// busy stays high while a pick searches. Reset clears the count and the total;
// the prefix table needs no clearing as only written entries are read.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module weighted_index_picker #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [wip_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [wip_pkg::WEIGHT_W-1:0]  weight_i,
  input  wire logic [wip_pkg::DRAW_W-1:0]    random_draw_i,
  output logic                               result_valid_o,
  output logic [wip_pkg::INDEX_W-1:0]        picked_index_o,
  output logic [wip_pkg::STATUS_W-1:0]       status_o,
  output logic [wip_pkg::COUNT_W-1:0]        entry_count_o
);
  import wip_pkg::*;

  // only the low weight bits that the port carries can count
  localparam int unsigned WB    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  // total < MAX_ENTRIES * 2^WB, so WB + IDX_W bits always suffice
  localparam int unsigned TOT_W = WB + IDX_W;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ENTRIES);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   entries_q, entries_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic [CNT_W-1:0]   lo_q, lo_d;
  logic [CNT_W-1:0]   hi_q, hi_d;
  logic [CNT_W-1:0]   mid_q, mid_d;
  logic               res_valid_q, res_valid_d;
  logic [INDEX_W-1:0] res_index_q, res_index_d;
  status_e            res_status_q, res_status_d;
  logic [COUNT_W-1:0] res_count_q, res_count_d;

  logic [TOT_W-1:0]   prefix_mem [MAX_ENTRIES];
  logic [TOT_W-1:0]   rdata_q;

  logic [TOT_W-1:0]   weight_ext;
  logic [TOT_W-1:0]   target;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   pick_k;
  logic               scale_en;
  logic               rd_en;
  logic               wr_en;

  assign weight_ext = TOT_W'(weight_i[WB-1:0]);
  assign mid        = lo_q + ((hi_q - lo_q) >> 1);
  // clamp to the last entry should the search run past the count
  assign pick_k     = (lo_q >= entries_q) ? (entries_q - CNT_W'(1)) : lo_q;

  wip_scale #(
    .TOT_W (TOT_W)
  ) u_scale (
    .clk_i    (clk_i),
    .en_i     (scale_en),
    .draw_i   (random_draw_i),
    .total_i  (total_q),
    .target_o (target)
  );

  always_comb begin
    state_d      = state_q;
    entries_d    = entries_q;
    total_d      = total_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    res_valid_d  = 1'b0;
    res_index_d  = res_index_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    scale_en     = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          res_index_d  = '0;
          res_status_d = ST_DONE;
          res_count_d  = COUNT_W'(entries_q);
          unique case (req_type_i)
            REQ_CLEAR: begin
              entries_d   = '0;
              total_d     = '0;
              res_count_d = '0;
              res_valid_d = 1'b1;
            end
            REQ_APPEND: begin
              res_valid_d = 1'b1;
              if (entries_q >= MAX_C) begin
                res_status_d = ST_FULL;
              end else if (weight_ext == '0) begin
                res_status_d = ST_ZERO;
              end else begin
                total_d     = total_q + weight_ext;
                entries_d   = entries_q + CNT_W'(1);
                wr_en       = 1'b1;
                res_count_d = COUNT_W'(entries_d);
              end
            end
            REQ_PICK: begin
              if (entries_q == '0) begin
                res_status_d = ST_EMPTY;
                res_valid_d  = 1'b1;
              end else begin
                scale_en = 1'b1;
                lo_d     = '0;
                hi_d     = entries_q;
                state_d  = S_ADDR;
              end
            end
            default: begin
              // unused code: nothing changes
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_ADDR: begin
        if (lo_q < hi_q) begin
          rd_en   = 1'b1;
          mid_d   = mid;
          state_d = S_CMP;
        end else begin
          res_valid_d  = 1'b1;
          res_index_d  = INDEX_W'(pick_k);
          res_status_d = ST_PICK_OK;
          res_count_d  = COUNT_W'(entries_q);
          state_d      = S_IDLE;
        end
      end
      S_CMP: begin
        if (rdata_q > target) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + CNT_W'(1);
        end
        state_d = S_ADDR;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entries_q   <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      entries_q   <= entries_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  // search bounds and result payload
  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    res_index_q  <= res_index_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
  end

  // prefix table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      prefix_mem[entries_q[IDX_W-1:0]] <= total_d;
    end
    if (rd_en) begin
      rdata_q <= prefix_mem[mid[IDX_W-1:0]];
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign picked_index_o = res_index_q;
  assign status_o       = res_status_q;
  assign entry_count_o  = res_count_q;

endmodule

`default_nettype wire
